[sv/ryc_pkg.sv]
// ----------------------------------------------------------------------------
// ryc_pkg
// Types, fixed-point coefficients and helper functions shared by the
// RGB / YCbCr color converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ryc_pkg;

  // Pixel component and working widths
  localparam int CompW = 8;
  localparam int CoefW = 18;   // signed 2.16 coefficients fit in 18 bits
  localparam int OperW = 9;    // signed operand: 0..255 or -128..127
  localparam int ProdW = OperW + CoefW;
  localparam int SumW  = 12;   // signed width of every term sum

  typedef logic [CompW-1:0]       comp_t;
  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [OperW-1:0] oper_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0]  sum_t;

  // Conversion direction codes
  typedef enum logic {
    DIR_RGB_TO_YCC = 1'b0,
    DIR_YCC_TO_RGB = 1'b1
  } dir_t;

  // Forward coefficients (signed 2.16)
  localparam coef_t K_Y_R  = 18'sd19595;
  localparam coef_t K_Y_G  = 18'sd38470;
  localparam coef_t K_Y_B  = 18'sd7471;
  localparam coef_t K_CB_R = -18'sd11056;
  localparam coef_t K_CB_G = -18'sd21712;
  localparam coef_t K_CR_G = -18'sd27440;
  localparam coef_t K_CR_B = -18'sd5328;

  // Inverse coefficients (signed 2.16)
  localparam coef_t K_R_CR = 18'sd91881;
  localparam coef_t K_G_CB = -18'sd22554;
  localparam coef_t K_G_CR = -18'sd46802;
  localparam coef_t K_B_CB = 18'sd112853;

  localparam sum_t  CHROMA_OFS  = 12'sd128;
  localparam oper_t CHROMA_OFS9 = 9'sd128;

  // Product floored to an integer: arithmetic shift by 16, sign-extended
  function automatic sum_t mul_floor(oper_t x, coef_t k);
    prod_t p;
    begin
      p = x * k;
      mul_floor = {p[ProdW-1], p[ProdW-1:16]};
    end
  endfunction

  // Saturate a signed sum to 0..255
  function automatic comp_t clamp8(sum_t v);
    begin
      if (v < 0) begin
        clamp8 = '0;
      end else if (v > 12'sd255) begin
        clamp8 = '1;
      end else begin
        clamp8 = v[CompW-1:0];
      end
    end
  endfunction

endpackage

`default_nettype wire

[sv/rgb_ycbcr_converter.sv]
// ----------------------------------------------------------------------------
// rgb_ycbcr_converter
// Full-range converter between 8-bit RGB and YCbCr (BT.601 forward matrix), one pixel per
// transfer, direction set by a one-bit configuration register.
// ----------------------------------------------------------------------------
// The converter takes one pixel per clock while the output side is not
// stalled. A pixel is captured in an input register, passes once through
// the constant multipliers, floors, sums and clamps in ryc_core, and lands
// in the output register; each register loads when it is empty or its
// content moves on, so the rate is one pixel per cycle without a stall,
// and a stall on the output backs up through in_stall one stage at a time.
// Write cfg_wr_data[0] with cfg_wr_en only while no pixel is in flight:
// 0 converts RGB to YCbCr, 1 converts YCbCr to RGB. Reset selects RGB to
// YCbCr and empties both registers.
`default_nettype none

module rgb_ycbcr_converter (
  input  var logic           clk,
  input  var logic           rst_n,
  input  var logic           cfg_wr_en,
  input  var logic           cfg_wr_data,
  input  var logic           in_valid,
  output logic               in_stall,
  input  var ryc_pkg::comp_t in_comp_a,
  input  var ryc_pkg::comp_t in_comp_b,
  input  var ryc_pkg::comp_t in_comp_c,
  output logic               out_valid,
  input  var logic           out_stall,
  output ryc_pkg::comp_t     out_a,
  output ryc_pkg::comp_t     out_b,
  output ryc_pkg::comp_t     out_c
);
  import ryc_pkg::*;

  dir_t  dir_r, dir_nxt;
  logic  s1_valid_r, s1_valid_nxt;
  dir_t  s1_dir_r;
  comp_t s1_a_r, s1_b_r, s1_c_r;
  logic  o_valid_r, o_valid_nxt;
  comp_t o_a_r, o_b_r, o_c_r;
  comp_t res_a, res_b, res_c;
  logic  o_free, s1_free, in_xfer, s1_move;

  // Direction register
  always_comb begin
    dir_nxt = dir_r;
    if (cfg_wr_en) begin
      dir_nxt = dir_t'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_RGB_TO_YCC;
    end else begin
      dir_r <= dir_nxt;
    end
  end

  // Flow control: a stage loads when it is empty or its content moves on
  assign o_free   = !o_valid_r || !out_stall;
  assign s1_free  = !s1_valid_r || o_free;
  assign in_stall = !rst_n || !s1_free;
  assign in_xfer  = in_valid && !in_stall;
  assign s1_move  = s1_valid_r && o_free;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_free) begin
      s1_valid_nxt = in_xfer;
    end
    o_valid_nxt = o_valid_r;
    if (o_free) begin
      o_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      o_valid_r  <= o_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_dir_r <= dir_r;
      s1_a_r   <= in_comp_a;
      s1_b_r   <= in_comp_b;
      s1_c_r   <= in_comp_c;
    end
  end

  // Color math
  ryc_core u_core (
    .dir    (s1_dir_r),
    .comp_a (s1_a_r),
    .comp_b (s1_b_r),
    .comp_c (s1_c_r),
    .res_a  (res_a),
    .res_b  (res_b),
    .res_c  (res_c)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (s1_move) begin
      o_a_r <= res_a;
      o_b_r <= res_b;
      o_c_r <= res_c;
    end
  end

  assign out_valid = o_valid_r;
  assign out_a     = o_a_r;
  assign out_b     = o_b_r;
  assign out_c     = o_c_r;

endmodule

`default_nettype wire

[sv/ryc_core.sv]
// ----------------------------------------------------------------------------
// ryc_core
// Combinational color math for one pixel: constant multipliers, per-term
// floor, sums and saturation for both conversion directions.
// ----------------------------------------------------------------------------
`default_nettype none

module ryc_core (
  input  var ryc_pkg::dir_t  dir,
  input  var ryc_pkg::comp_t comp_a,
  input  var ryc_pkg::comp_t comp_b,
  input  var ryc_pkg::comp_t comp_c,
  output ryc_pkg::comp_t     res_a,
  output ryc_pkg::comp_t     res_b,
  output ryc_pkg::comp_t     res_c
);
  import ryc_pkg::*;

  oper_t a9, b9, c9, u9, v9;
  sum_t  a12, a_half, c_half;
  sum_t  y_sum, cb_sum, cr_sum;
  sum_t  r_sum, g_sum, b_sum;

  // Operands: plain components and chroma with the offset removed
  assign a9     = oper_t'({1'b0, comp_a});
  assign b9     = oper_t'({1'b0, comp_b});
  assign c9     = oper_t'({1'b0, comp_c});
  assign u9     = b9 - CHROMA_OFS9;
  assign v9     = c9 - CHROMA_OFS9;
  assign a12    = sum_t'({4'b0, comp_a});
  assign a_half = sum_t'({5'b0, comp_a[CompW-1:1]});
  assign c_half = sum_t'({5'b0, comp_c[CompW-1:1]});

  // RGB -> YCbCr
  assign y_sum  = mul_floor(a9, K_Y_R) + mul_floor(b9, K_Y_G) + mul_floor(c9, K_Y_B);
  assign cb_sum = mul_floor(a9, K_CB_R) + mul_floor(b9, K_CB_G) + c_half + CHROMA_OFS;
  assign cr_sum = a_half + mul_floor(b9, K_CR_G) + mul_floor(c9, K_CR_B) + CHROMA_OFS;

  // YCbCr -> RGB
  assign r_sum = a12 + mul_floor(v9, K_R_CR);
  assign g_sum = a12 + mul_floor(u9, K_G_CB) + mul_floor(v9, K_G_CR);
  assign b_sum = a12 + mul_floor(u9, K_B_CB);

  // Direction select and saturation
  always_comb begin
    case (dir)
      DIR_RGB_TO_YCC: begin
        res_a = clamp8(y_sum);
        res_b = clamp8(cb_sum);
        res_c = clamp8(cr_sum);
      end
      DIR_YCC_TO_RGB: begin
        res_a = clamp8(r_sum);
        res_b = clamp8(g_sum);
        res_c = clamp8(b_sum);
      end
      default: begin
        res_a = clamp8(y_sum);
        res_b = clamp8(cb_sum);
        res_c = clamp8(cr_sum);
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/ryc_checker.sv]
// ----------------------------------------------------------------------------
// ryc_checker
// Port-level checks for the color converter: reset, result hold under
// stall, an input transfer behind each new result and full throughput.
// ----------------------------------------------------------------------------
`default_nettype none

module ryc_checker (
  input var logic           clk,
  input var logic           rst_n,
  input var logic           in_valid,
  input var logic           in_stall,
  input var logic           out_valid,
  input var logic           out_stall,
  input var ryc_pkg::comp_t out_a,
  input var ryc_pkg::comp_t out_b,
  input var ryc_pkg::comp_t out_c
);
  import ryc_pkg::*;

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result stays in place
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_a) && $stable(out_b) && $stable(out_c))
    else $error("stalled result changed");

  // A result appearing in an empty output comes from an input transfer through the input register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without matching input transfer");

  // Input is never stalled while the output side can move
  a_throughput: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || !out_stall |-> !in_stall)
    else $error("input stalled with free output");

endmodule

bind rgb_ycbcr_converter ryc_checker u_ryc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_a     (out_a),
  .out_b     (out_b),
  .out_c     (out_c)
);

`default_nettype wire
